// ----- hdl/jch_pkg.sv -----
// Shared types and constants for the jump consistent hash block.
// No dependencies; used by the top level and by jch_div_step.
`default_nettype none

package jch_pkg;

  // Key advance multiplier, split into 32-bit halves for the shared multiplier.
  localparam logic [63:0] MULT    = 64'd2862933555777941757;
  localparam logic [31:0] MULT_LO = MULT[31:0];
  localparam logic [31:0] MULT_HI = MULT[63:32];

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_MUL0 = 10'b00_0000_0010,
    ST_MUL1 = 10'b00_0000_0100,
    ST_MUL2 = 10'b00_0000_1000,
    ST_MUL3 = 10'b00_0001_0000,
    ST_PREP = 10'b00_0010_0000,
    ST_OVF  = 10'b00_0100_0000,
    ST_DIV  = 10'b00_1000_0000,
    ST_CHK  = 10'b01_0000_0000,
    ST_DONE = 10'b10_0000_0000
  } state_t;

  // Result of one compare-and-subtract step.
  typedef struct packed {
    logic        ge;
    logic [31:0] diff;
  } step_res_t;

endpackage

`default_nettype wire

// ----- hdl/jump_consistent_hash_top.sv -----
// Top level of the jump consistent hash block: sequencer, registers and output stage.
// Depends on jch_pkg, jch_mul32 and jch_div_step.
`default_nettype none

//  Channel | Ports                              | Direction | Moves
//  --------+------------------------------------+-----------+-----------------------------
//  input   | in_valid, in_stall, in_key         | in        | one 64-bit key
//  result  | out_valid, out_stall, out_bucket   | out       | one bucket index per key
//  config  | cfg_wr_en, cfg_wr_data             | in        | bucket_count, write only
//
//  Each pass of the hash loop runs ST_MUL0 to ST_MUL3 on the shared 32x32 multiplier for
//  the key advance, forms the divisor in ST_PREP, runs one overflow test and one
//  restoring-division step per quotient bit on the shared subtractor, and one compare.
//  A key takes about ln(bucket_count) + 1 passes, plus the accept and deliver states.
//  Reset is synchronous and active low; it restores bucket_count to 10 and idles the
//  sequencer. No clearing pass is needed. The result sits in an output register, so a
//  new transaction is accepted while an earlier result is still stalled.

module jump_consistent_hash_top #(
  parameter int BUCKET_BITS = 31
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [63:0]            in_key,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [BUCKET_BITS-1:0] out_bucket,
  input  wire logic                   cfg_wr_en,
  input  wire logic [BUCKET_BITS-1:0] cfg_wr_data
);

  localparam int CW = (BUCKET_BITS > 1) ? $clog2(BUCKET_BITS) : 1;
  localparam int SH = 31 - BUCKET_BITS;
  localparam logic [BUCKET_BITS-1:0] BC_RESET = BUCKET_BITS'(10);

  jch_pkg::state_t         state_r, state_nxt;
  logic [BUCKET_BITS-1:0]  bc_r;
  logic [63:0]             key_r, key_nxt;
  logic [63:0]             acc_r, acc_nxt;
  logic [BUCKET_BITS-1:0]  b_r, b_nxt;
  logic [BUCKET_BITS-1:0]  q_r, q_nxt;
  logic [31:0]             rem_r, rem_nxt;
  logic [31:0]             d_r, d_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    out_valid_r;
  logic [BUCKET_BITS-1:0]  out_bucket_r;

  logic [31:0]             mul_a, mul_b;
  logic [63:0]             prod;
  logic [32:0]             step_a;
  jch_pkg::step_res_t      step;
  logic                    in_acc, out_free, j_below;

  // Shared arithmetic: one multiplier for the key advance, one subtractor for division.
  jch_mul32 u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  jch_div_step u_step (
    .a   (step_a),
    .d   (d_r),
    .res (step)
  );

  assign in_stall   = (state_r != jch_pkg::ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_bucket = out_bucket_r;

  // A bucket count of zero behaves as one bucket.
  assign j_below = (bc_r == '0) ? (q_r == '0) : (q_r < bc_r);

  // Operand selection for the low 64 bits of key * MULT: lo*lo, lo*hi, hi*lo.
  always_comb begin
    mul_a = key_r[31:0];
    mul_b = jch_pkg::MULT_LO;
    case (state_r)
      jch_pkg::ST_MUL1: begin
        mul_b = jch_pkg::MULT_HI;
      end
      jch_pkg::ST_MUL2: begin
        mul_a = key_r[63:32];
      end
      default: begin
        mul_a = key_r[31:0];
      end
    endcase
  end

  // The overflow test compares the numerator's upper part with the divisor; the
  // division steps shift the partial remainder left by one, taking in a zero bit.
  assign step_a = (state_r == jch_pkg::ST_OVF) ? {1'b0, rem_r} : {rem_r, 1'b0};

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    acc_nxt   = acc_r;
    b_nxt     = b_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    d_nxt     = d_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      jch_pkg::ST_IDLE: begin
        if (in_acc) begin
          key_nxt   = in_key;
          b_nxt     = '0;
          state_nxt = jch_pkg::ST_MUL0;
        end
      end
      jch_pkg::ST_MUL0: begin
        state_nxt = jch_pkg::ST_MUL1;
      end
      jch_pkg::ST_MUL1: begin
        acc_nxt   = prod;
        state_nxt = jch_pkg::ST_MUL2;
      end
      jch_pkg::ST_MUL2: begin
        acc_nxt   = acc_r + {prod[31:0], 32'd0};
        state_nxt = jch_pkg::ST_MUL3;
      end
      jch_pkg::ST_MUL3: begin
        key_nxt   = acc_r + {prod[31:0], 32'd0} + 64'd1;
        state_nxt = jch_pkg::ST_PREP;
      end
      jch_pkg::ST_PREP: begin
        // Numerator is (b + 1) << 31; its part above the quotient width is kept here.
        d_nxt     = {1'b0, key_r[63:33]} + 32'd1;
        rem_nxt   = ({{(32-BUCKET_BITS){1'b0}}, b_r} + 32'd1) << SH;
        state_nxt = jch_pkg::ST_OVF;
      end
      jch_pkg::ST_OVF: begin
        // A quotient that would not fit in BUCKET_BITS lies past every bucket.
        if (step.ge) begin
          state_nxt = jch_pkg::ST_DONE;
        end else begin
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = jch_pkg::ST_DIV;
        end
      end
      jch_pkg::ST_DIV: begin
        rem_nxt = step.ge ? step.diff : step_a[31:0];
        q_nxt   = BUCKET_BITS'({q_r, step.ge});
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(BUCKET_BITS - 1)) begin
          state_nxt = jch_pkg::ST_CHK;
        end
      end
      jch_pkg::ST_CHK: begin
        if (j_below) begin
          b_nxt     = q_r;
          state_nxt = jch_pkg::ST_MUL0;
        end else begin
          state_nxt = jch_pkg::ST_DONE;
        end
      end
      jch_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = jch_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = jch_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jch_pkg::ST_IDLE;
      bc_r        <= BC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        bc_r <= cfg_wr_data;
      end
      if (state_r == jch_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    if (state_r == jch_pkg::ST_DONE && out_free) begin
      out_bucket_r <= b_r;
    end
  end

  // Each pass that completes a division moves the candidate strictly forward.
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jch_pkg::ST_CHK) |-> (q_r > b_r))
    else $error("hash loop candidate did not advance");

  // A new result only appears after the sequencer has finished a key.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == jch_pkg::ST_DONE))
    else $error("result raised outside the done state");

  // The division step counter never runs past the quotient width.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jch_pkg::ST_DIV) |-> (cnt_r <= CW'(BUCKET_BITS - 1)))
    else $error("division step counter out of range");

endmodule

`default_nettype wire

// ----- hdl/jch_mul32.sv -----
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// Depends on nothing outside this file.
`default_nettype none

module jch_mul32 (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= {32'd0, a} * {32'd0, b};
  end

endmodule

`default_nettype wire

// ----- hdl/jch_div_step.sv -----
// Shared compare-and-subtract unit for the restoring divider and its overflow test.
// Depends on jch_pkg for the step result struct.
`default_nettype none

module jch_div_step (
  input  wire logic [32:0]       a,
  input  wire logic [31:0]       d,
  output jch_pkg::step_res_t     res
);

  logic [33:0] sub;

  assign sub      = {1'b0, a} - {2'b00, d};
  assign res.ge   = ~sub[33];
  assign res.diff = sub[31:0];

endmodule

`default_nettype wire

// ----- bench/jump_consistent_hash_top_test.sv -----
// Self-checking testbench for jump_consistent_hash_top: directed keys, then random phases.
// Depends only on the RTL under hdl (jch_pkg and the top level with its submodules).
`default_nettype none

module jump_consistent_hash_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BB = 31;

  // Key advance of the hash loop, a 64-bit LCG step.
  localparam logic [63:0] KEY_MULT = 64'd2862933555777941757;
  localparam logic [BB-1:0] RESET_COUNT = 31'd10;
  localparam logic [BB-1:0] MAX_COUNT = 31'h7FFF_FFFF;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // A maximal bucket count needs about 22 passes of the hash loop per key, which bounds the
  // time one key may take. The deliberate receiver hold-off lasts HOLD_CYCLES. The watchdog
  // limit is several times the sum of that key time and the hold-off.
  localparam int HOLD_CYCLES = 3000;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1000;
  localparam int NUM_PHASES = 14;
  localparam int KEYS_PER_PHASE = 100;
  localparam int MAX_REPORTS = 10;

  // One row of the directed table. When has_bucket is set the expected bucket is the one
  // typed into the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic [BB-1:0] count;
    logic [63:0]   key;
    logic          has_bucket;
    logic [BB-1:0] bucket;
  } directed_row_t;

  localparam int NUM_DIRECTED = 21;

  // A key of zero advances to one, whose divisor is one, so the first candidate is 2^31
  // and the answer is bucket 0 for every count the register can hold. Counts of zero and
  // one both leave bucket 0 as the only choice.
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{RESET_COUNT, 64'd0,                    1'b1, 31'd0},
    '{RESET_COUNT, ALL_ONES,                 1'b0, 31'd0},
    '{RESET_COUNT, 64'd1,                    1'b0, 31'd0},
    '{RESET_COUNT, 64'h8000_0000_0000_0000,  1'b0, 31'd0},
    '{RESET_COUNT, 64'h5555_5555_5555_5555,  1'b0, 31'd0},
    '{RESET_COUNT, 64'hAAAA_AAAA_AAAA_AAAA,  1'b0, 31'd0},
    '{RESET_COUNT, 64'h0000_0001_FFFF_FFFF,  1'b0, 31'd0},
    '{RESET_COUNT, 64'h0000_0002_0000_0000,  1'b0, 31'd0},
    '{31'd0,       ALL_ONES,                 1'b1, 31'd0},
    '{31'd0,       64'hDEAD_BEEF_CAFE_F00D,  1'b1, 31'd0},
    '{31'd1,       ALL_ONES,                 1'b1, 31'd0},
    '{31'd1,       64'h5555_5555_5555_5555,  1'b1, 31'd0},
    '{31'd2,       64'h0123_4567_89AB_CDEF,  1'b0, 31'd0},
    '{31'd2,       ALL_ONES,                 1'b0, 31'd0},
    '{31'd2,       64'hAAAA_AAAA_AAAA_AAAA,  1'b0, 31'd0},
    '{MAX_COUNT,   64'd0,                    1'b1, 31'd0},
    '{MAX_COUNT,   ALL_ONES,                 1'b0, 31'd0},
    '{MAX_COUNT,   64'h5555_5555_5555_5555,  1'b0, 31'd0},
    '{MAX_COUNT,   64'h8000_0000_0000_0000,  1'b0, 31'd0},
    '{31'd1000,    64'hFEDC_BA98_7654_3210,  1'b0, 31'd0},
    '{31'd1000,    64'd42,                   1'b0, 31'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] in_key = 64'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BB-1:0] out_bucket;
  logic cfg_wr_en = 1'b0;
  logic [BB-1:0] cfg_wr_data = '0;

  // Side information that travels with the key currently offered.
  logic key_has_bucket = 1'b0;
  logic [BB-1:0] key_bucket = '0;

  // Testbench copy of the bucket_count register.
  logic [BB-1:0] model_count = RESET_COUNT;

  logic [BB-1:0] expected_buckets[$];
  int unsigned results_seen = 0;
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;

  // Points, in delivered results, at which the receiver holds off for a long stretch.
  int unsigned hold_points[2] = '{150, 800};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  jump_consistent_hash_top #(
    .BUCKET_BITS(BB)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_bucket (out_bucket),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Bucket chosen for a key under the given count. The quotient is an exact unsigned
  // floor; a count of zero behaves as one.
  function automatic logic [BB-1:0] jump_bucket_of(input logic [63:0] key,
                                                   input logic [BB-1:0] count);
    logic [63:0] state;
    logic [63:0] limit;
    logic [63:0] cur;
    logic [63:0] cand;
    state = key;
    limit = (count == '0) ? 64'd1 : 64'(count);
    cur = 64'd0;
    cand = 64'd0;
    while (cand < limit) begin
      cur = cand;
      state = state * KEY_MULT + 64'd1;
      cand = ((cur + 64'd1) << 31) / ((state >> 33) + 64'd1);
    end
    return cur[BB-1:0];
  endfunction

  // Gap lengths: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  // Random keys, with zero, all ones and single set bits mixed in.
  function automatic logic [63:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 64'd0;
    if (r == 1) return ALL_ONES;
    if (r == 2) return 64'd1 << $urandom_range(0, 63);
    return {$urandom, $urandom};
  endfunction

  // Bucket counts for the random phases. The first few phases pin the extremes; the rest
  // favor small counts, because the run time of a key grows with the log of the count.
  function automatic logic [BB-1:0] pick_count(input int phase);
    int unsigned r;
    case (phase)
      0: return MAX_COUNT;
      1: return 31'd0;
      2: return 31'd1;
      3: return 31'd2;
      default: begin
        r = $urandom_range(0, 9);
        if (r < 4) return BB'($urandom_range(3, 16));
        if (r < 7) return BB'($urandom_range(17, 5000));
        if (r < 9) return BB'($urandom_range(5001, 1 << 20));
        return BB'($urandom);
      end
    endcase
  endfunction

  // Writes bucket_count once the block has delivered every result it owes. Every key
  // yields a result, so an empty queue means the sequencer is idle. The first edge lets
  // the monitor record a key that was accepted at the edge the sender just left.
  task automatic load_bucket_count(input logic [BB-1:0] count);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_buckets.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_count = count;
  endtask

  // Offers one key and holds it until the block accepts it, then idles for a while
  // unless the current phase runs back to back.
  task automatic send_key(input logic [63:0] key, input logic has_bucket,
                          input logic [BB-1:0] bucket, input bit back_to_back);
    int unsigned gap;
    in_valid <= 1'b1;
    in_key <= key;
    key_has_bucket <= has_bucket;
    key_bucket <= bucket;
    do @(posedge clk); while (in_stall);
    gap = back_to_back ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender: reset, the directed table, then the random phases, then the drain.
  initial begin
    logic [BB-1:0] count;
    bit back_to_back;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first rows run on the reset value of bucket_count; later rows write it when
    // their count differs from the one in force.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].count != model_count) begin
        load_bucket_count(DIRECTED_ROWS[i].count);
      end
      send_key(DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].has_bucket,
               DIRECTED_ROWS[i].bucket, 1'b0);
    end

    // Each phase waits for the block to drain before it changes the count, which is
    // also where the sender pauses until every result is in.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      count = pick_count(phase);
      load_bucket_count(count);
      back_to_back = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < KEYS_PER_PHASE; k++) begin
        send_key(pick_key(), 1'b0, '0, back_to_back);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_buckets.size() != 0) @(posedge clk);
    // Anything the block sends after this point has no expectation and fails the run.
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures += expected_buckets.size();
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: ready stretches of random length, sometimes long, broken by stalls. At each
  // hold point it stalls for HOLD_CYCLES while the sender keeps offering keys, so the
  // output register fills, the sequencer finishes the next key and the input stalls.
  initial begin
    int unsigned hold_next;
    int unsigned n;
    hold_next = 0;
    @(posedge clk);
    forever begin
      if (hold_next < 2 && results_seen >= hold_points[hold_next]) begin
        hold_next++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
        repeat (n) @(posedge clk);
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // Monitor: records the expected bucket of each accepted key, checks each delivered
  // result against the oldest expectation, and runs the watchdog. All values are sampled
  // at the edge, before any nonblocking update of that edge lands.
  always @(posedge clk) begin
    logic [BB-1:0] want;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        expected_buckets.push_back(key_has_bucket ? key_bucket
                                                  : jump_bucket_of(in_key, model_count));
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        results_seen++;
        if (expected_buckets.size() == 0) begin
          if (failures < MAX_REPORTS) begin
            $display("unexpected result transaction: bucket %0d", out_bucket);
          end
          failures++;
        end else begin
          want = expected_buckets.pop_front();
          if (out_bucket !== want) begin
            if (failures < MAX_REPORTS) begin
              $display("bucket mismatch on result %0d: expected %0d, got %0d",
                       results_seen, want, out_bucket);
            end
            failures++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
